[sv/relative_strength_index_macros.svh]
// Assertion macros shared by the relative strength index RTL.
// Expects signals named clk and rst_n in the module that uses them.
// Define NO_ASSERTIONS to compile the macros to nothing.
`ifndef RELATIVE_STRENGTH_INDEX_MACROS_SVH
`define RELATIVE_STRENGTH_INDEX_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every clock edge out of reset
`define RSI_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RSI_ASSERT_IMPLY(label, ante, cons, msg)
`define RSI_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[sv/rsi_pkg.sv]
// Shared constants and controller/datapath interface types for the
// relative strength index block. No dependencies.
package rsi_pkg;

    // Smoothing period register
    localparam int unsigned   PERIOD_W     = 8;
    localparam logic [7:0]    PERIOD_RESET = 8'd7;
    localparam logic [7:0]    PERIOD_MIN   = 8'd2;

    // Warm-up counter: 0 = no series, else 1 + changes summed (max 256)
    localparam int unsigned   COUNT_W      = 9;
    localparam logic [8:0]    COUNT_MAX    = 9'd256;

    // Price changes are scaled up by this many bits before averaging
    localparam int unsigned   AVG_EXTRA    = 8;
    // Averages are this many bits wider than the price
    localparam int unsigned   AVG_GROW     = 16;

    // Index output: units of 1/256, full scale 100
    localparam int unsigned   RSI_BITS     = 15;
    localparam int unsigned   RSI_IDX_W    = 4;
    localparam int unsigned   RSI_DATA_W   = 16;
    localparam logic [14:0]   RSI_FULL     = 15'd25600;

    // Controller -> datapath commands
    typedef struct packed {
        logic latch_in;   // capture input transaction, form gain/loss move
        logic do_start;   // open a new series
        logic do_warm;    // add move into warm-up sums
        logic do_mul;     // avg * (p-1) into product registers
        logic do_add;     // product + move into dividend
        logic div_start;  // clear remainders, load bit counter
        logic div_step;   // one restoring division step (both lanes)
        logic rsi_init;   // store averages, set up index division
        logic rsi_a;      // index division: shift and subtract
        logic rsi_b;      // index division: add gain where constant bit set
        logic rsi_round;  // round to nearest
        logic load_out;   // move result into output register
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic start;      // item opens a series
        logic warm;       // still summing warm-up changes
        logic warm_last;  // this change ends warm-up
        logic cnt_zero;   // bit counter at zero
        logic loss_zero;  // average loss is zero
        logic out_free;   // output register can take a result
    } status_t;

endpackage

[sv/rsi_ctrl.sv]
// Sequencing state machine for the relative strength index block.
// Depends on rsi_pkg (cmd_t, status_t).
module rsi_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rsi_pkg::status_t  st,
    output rsi_pkg::cmd_t     cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_ADD   = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_SUM   = 9'b000010000,
        S_RSI_A = 9'b000100000,
        S_RSI_B = 9'b001000000,
        S_ROUND = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_PREP;
                end
            end
            S_PREP:
            begin
                priority if (st.start)
                begin
                    cmd.do_start = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (st.warm)
                begin
                    cmd.do_warm = 1'b1;
                    if (st.warm_last)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.do_mul = 1'b1;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.do_add    = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.cnt_zero)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.rsi_init = 1'b1;
                state_next   = st.loss_zero ? S_EMIT : S_RSI_A;
            end
            S_RSI_A:
            begin
                cmd.rsi_a  = 1'b1;
                state_next = S_RSI_B;
            end
            S_RSI_B:
            begin
                cmd.rsi_b  = 1'b1;
                state_next = st.cnt_zero ? S_ROUND : S_RSI_A;
            end
            S_ROUND:
            begin
                cmd.rsi_round = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/rsi_datapath.sv]
// Datapath of the relative strength index block: series state, averaging,
// two-lane serial divider, bit-serial index divider and output register.
// Depends on rsi_pkg and relative_strength_index_macros.svh.
`include "relative_strength_index_macros.svh"

module rsi_datapath #(
    parameter int PRICE_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rsi_pkg::PERIOD_W-1:0]  cfg_data,
    input  logic [PRICE_WIDTH-1:0]        in_price,
    input  logic                          in_new,
    input  rsi_pkg::cmd_t                 cmd,
    output rsi_pkg::status_t              st,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [rsi_pkg::RSI_BITS-1:0]  out_rsi,
    output logic                          out_first
);

    localparam int PW    = rsi_pkg::PERIOD_W;
    localparam int AVG_W = PRICE_WIDTH + rsi_pkg::AVG_GROW;
    localparam int MOV_W = PRICE_WIDTH + rsi_pkg::AVG_EXTRA;
    localparam int PRD_W = AVG_W + PW;
    localparam int NUM_W = PRD_W + 1;
    localparam int D_W   = AVG_W + 1;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int RB    = rsi_pkg::RSI_BITS;

    // lane 0 = gain, lane 1 = loss
    logic [PW-1:0]                     period_reg;
    logic [PRICE_WIDTH-1:0]            prev_reg;
    logic [1:0][AVG_W-1:0]             avg_reg;
    logic [rsi_pkg::COUNT_W-1:0]       count_reg;
    logic                              m_tvalid_reg;

    logic [PRICE_WIDTH-1:0]            price_reg;
    logic                              new_reg;
    logic [1:0][MOV_W-1:0]             move_reg;
    logic [1:0][PRD_W-1:0]             prod_reg;
    logic [1:0][NUM_W-1:0]             num_reg;
    logic [1:0][PW-1:0]                rem_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [D_W-1:0]                    d_reg;
    logic [D_W-1:0]                    r_reg;
    logic [RB-1:0]                     q_reg;
    logic                              first_reg;
    logic [RB-1:0]                     out_rsi_reg;
    logic                              out_first_reg;

    logic [PW-1:0]                     p_eff;
    logic [PW-1:0]                     p_m1;
    logic                              price_up;
    logic [PRICE_WIDTH-1:0]            diff_up;
    logic [PRICE_WIDTH-1:0]            diff_down;
    logic [1:0][AVG_W-1:0]             warm_sum;
    logic [1:0][PRD_W-1:0]             prod_next;
    logic [1:0][PW:0]                  rem_sh;
    logic [1:0][PW:0]                  rem_sub;
    logic [1:0]                        div_ge;
    logic [D_W-1:0]                    d_sum;
    logic [D_W:0]                      r2;
    logic [D_W:0]                      r2_sub;
    logic                              a_ge;
    logic [D_W:0]                      rg;
    logic [D_W:0]                      rg_sub;
    logic                              b_ge;
    logic                              full_bit;

    // Effective period, values below two act as two
    always_comb
    begin
        p_eff = (period_reg < rsi_pkg::PERIOD_MIN) ? rsi_pkg::PERIOD_MIN : period_reg;
        p_m1  = p_eff - PW'(1);
    end

    // Price move from the incoming price
    always_comb
    begin
        price_up  = in_price > prev_reg;
        diff_up   = in_price - prev_reg;
        diff_down = prev_reg - in_price;
    end

    // Per-lane averaging and restoring division step
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            warm_sum[l]  = avg_reg[l] + AVG_W'(move_reg[l]);
            prod_next[l] = avg_reg[l] * p_m1;
            rem_sh[l]    = {rem_reg[l], num_reg[l][NUM_W-1]};
            div_ge[l]    = rem_sh[l] >= {1'b0, p_eff};
            rem_sub[l]   = rem_sh[l] - {1'b0, p_eff};
        end
    end

    // Index division: 25600 * gain / (gain + loss), one half-step a cycle
    always_comb
    begin
        d_sum    = D_W'(num_reg[0][AVG_W-1:0]) + D_W'(num_reg[1][AVG_W-1:0]);
        r2       = {r_reg, 1'b0};
        a_ge     = r2 >= {1'b0, d_reg};
        r2_sub   = r2 - {1'b0, d_reg};
        rg       = {1'b0, r_reg} + (D_W + 1)'(avg_reg[0]);
        b_ge     = rg >= {1'b0, d_reg};
        rg_sub   = rg - {1'b0, d_reg};
        full_bit = rsi_pkg::RSI_FULL[cnt_reg[rsi_pkg::RSI_IDX_W-1:0]];
    end

    // Status to controller
    always_comb
    begin
        st.start     = new_reg || (count_reg == '0);
        st.warm      = count_reg <= {1'b0, p_eff};
        st.warm_last = count_reg == {1'b0, p_eff};
        st.cnt_zero  = cnt_reg == '0;
        st.loss_zero = num_reg[1][AVG_W-1:0] == '0;
        st.out_free  = !m_tvalid_reg || m_tready;
    end

    // Configuration, series state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= rsi_pkg::PERIOD_RESET;
            prev_reg     <= '0;
            avg_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                period_reg <= cfg_data;
            end
            if (cmd.do_start || cmd.do_warm || cmd.do_mul)
            begin
                prev_reg <= price_reg;
            end
            priority if (cmd.do_start)
            begin
                avg_reg   <= '0;
                count_reg <= rsi_pkg::COUNT_W'(1);
            end
            else if (cmd.do_warm)
            begin
                avg_reg   <= warm_sum;
                count_reg <= count_reg + rsi_pkg::COUNT_W'(1);
            end
            else if (cmd.rsi_init)
            begin
                avg_reg[0] <= num_reg[0][AVG_W-1:0];
                avg_reg[1] <= num_reg[1][AVG_W-1:0];
            end
            if (cmd.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Input capture and products
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            price_reg   <= in_price;
            new_reg     <= in_new;
            move_reg[0] <= price_up ? {diff_up, {rsi_pkg::AVG_EXTRA{1'b0}}} : '0;
            move_reg[1] <= price_up ? '0 : {diff_down, {rsi_pkg::AVG_EXTRA{1'b0}}};
        end
        if (cmd.do_mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.do_warm)
        begin
            first_reg <= 1'b1;
        end
        else if (cmd.do_mul)
        begin
            first_reg <= 1'b0;
        end
    end

    // Two-lane serial divider by the period
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            priority if (cmd.do_warm)
            begin
                num_reg[l] <= NUM_W'(warm_sum[l]);
            end
            else if (cmd.do_add)
            begin
                num_reg[l] <= NUM_W'(prod_reg[l]) + NUM_W'(move_reg[l]);
            end
            else if (cmd.div_step)
            begin
                num_reg[l] <= {num_reg[l][NUM_W-2:0], div_ge[l]};
            end
            if (cmd.div_start)
            begin
                rem_reg[l] <= '0;
            end
            else if (cmd.div_step)
            begin
                rem_reg[l] <= div_ge[l] ? rem_sub[l][PW-1:0] : rem_sh[l][PW-1:0];
            end
        end
    end

    // Shared bit counter
    always_ff @(posedge clk)
    begin
        priority if (cmd.div_start)
        begin
            cnt_reg <= CNT_W'(NUM_W - 1);
        end
        else if (cmd.rsi_init)
        begin
            cnt_reg <= CNT_W'(RB - 1);
        end
        else if (cmd.div_step || cmd.rsi_b)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Index quotient and remainder
    always_ff @(posedge clk)
    begin
        priority if (cmd.rsi_init)
        begin
            d_reg <= d_sum;
            r_reg <= '0;
            q_reg <= (num_reg[1][AVG_W-1:0] == '0) ? rsi_pkg::RSI_FULL : '0;
        end
        else if (cmd.rsi_a)
        begin
            r_reg <= a_ge ? r2_sub[D_W-1:0] : r2[D_W-1:0];
            q_reg <= {q_reg[RB-2:0], a_ge};
        end
        else if (cmd.rsi_b)
        begin
            if (full_bit)
            begin
                r_reg <= b_ge ? rg_sub[D_W-1:0] : rg[D_W-1:0];
                q_reg <= q_reg + RB'(b_ge);
            end
        end
        else if (cmd.rsi_round)
        begin
            q_reg <= q_reg + RB'(a_ge);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_rsi_reg   <= q_reg;
            out_first_reg <= first_reg;
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign out_rsi   = out_rsi_reg;
    assign out_first = out_first_reg;

    // Checks
    `RSI_ASSERT_IMPLY(a_rem_below_sum, cmd.rsi_a, r_reg < d_reg, "index remainder not below sum")
    `RSI_ASSERT_NEXT(a_rem_after_add, cmd.rsi_b, r_reg < d_reg, "remainder escaped after add")
    `RSI_ASSERT_IMPLY(a_rsi_range, m_tvalid_reg, out_rsi_reg <= rsi_pkg::RSI_FULL, "index above 100")
    `RSI_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= rsi_pkg::COUNT_MAX, "warm-up count overrun")

endmodule

[sv/relative_strength_index.sv]
// Top level of the Wilder relative strength index block.
// Depends on rsi_pkg, rsi_ctrl and rsi_datapath.
//
// Usage:
//   Slave stream carries one closing price per transaction in s_tdata and a
//   new-series flag in s_tuser. Master stream returns the index in m_tdata
//   (1/256 units, 0..25600) with m_tuser high on the first index of a series.
//   cfg_we/cfg_data write the smoothing period; write only while idle.
// Sequencing:
//   A series start or a warm-up price before the last one returns nothing.
//   A smoothed index passes through the product step, the serial divider
//   by the period, the bit-serial index divider and rounding. The index
//   that ends warm-up skips the product step; a zero loss average skips
//   the index divider and rounding.
//   One price is worked on at a time; s_tready is high only while idle.
// Reset:
//   Clears the series (next price opens one) and sets the period to 7.
// Stall:
//   The result waits in the output register; the next price is taken
//   meanwhile and its result waits until the register is emptied.
module relative_strength_index #(
    parameter int PRICE_WIDTH = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration
    input  logic                            cfg_we,
    input  logic [rsi_pkg::PERIOD_W-1:0]    cfg_data,   // smoothing_period
    // Price stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [((PRICE_WIDTH+7)/8)*8-1:0] s_tdata,   // close_price, zero pad
    input  logic                            s_tuser,    // new_series
    // Index stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rsi_pkg::RSI_DATA_W-1:0]  m_tdata,    // rsi_value, zero pad
    output logic                            m_tuser     // is_first
);

    rsi_pkg::cmd_t                  cmd;
    rsi_pkg::status_t               st;
    logic [rsi_pkg::RSI_BITS-1:0]   out_rsi;

    // Sequencer
    rsi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Arithmetic and state
    rsi_datapath #(
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_price  (s_tdata[PRICE_WIDTH-1:0]),
        .in_new    (s_tuser),
        .cmd       (cmd),
        .st        (st),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_rsi   (out_rsi),
        .out_first (m_tuser)
    );

    assign m_tdata = {{(rsi_pkg::RSI_DATA_W - rsi_pkg::RSI_BITS){1'b0}}, out_rsi};

endmodule
